FILE: rtl/bdlp_pkg.sv
// Shared types and constants for the button debounce and long-press block.
package bdlp_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd2;

    localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd200;
    localparam logic [CFG_W-1:0] SETTLE_RST  = 16'd30;
    localparam logic [CFG_W-1:0] LONG_RST    = 16'd700;

    localparam int DIR_N = 4;

    typedef struct packed {
        logic up_level;
        logic down_level;
        logic left_level;
        logic right_level;
        logic select_level;
    } t_in;

    typedef struct packed {
        logic up_event;
        logic down_event;
        logic left_event;
        logic right_event;
        logic select_short_event;
        logic select_long_event;
    } t_out;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } t_sel_ev;

endpackage

FILE: rtl/button_debounce_long_press_core.sv
// Five-button front end: one beat in is one timer tick with the raw active-low
// levels; one beat out follows with the press events of that tick. The block
// takes a beat every cycle while not stalled; the output register holds its
// result from the next cycle, and lets the next tick enter while a result
// waits, so input stall rises only when that result is held and the output
// side stalls. Up, down, left and right report a press on a falling edge and
// then ignore edges for lockout_ticks ticks. Select is confirmed after
// settle_ticks quiet ticks, reports a long press after long_press_ticks of
// confirmed hold, and a short press on a confirmed release otherwise.
// Register values above the counter range saturate to the largest count.
module button_debounce_long_press_core #(
    parameter int COUNT_BITS = bdlp_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bdlp_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bdlp_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int CW = bdlp_pkg::CFG_W;

    logic [CW-1:0]         r_lockout, r_settle, r_long;
    logic [COUNT_BITS-1:0] lockout_lim, settle_lim, long_lim;
    logic [4:0]            r_prev;
    logic [4:0]            levels;
    logic [3:0]            dir_ev;
    bdlp_pkg::t_sel_ev     sel_ev;
    logic                  r_out_valid;
    bdlp_pkg::t_out        r_out_data;
    bdlp_pkg::t_out        n_out_data;
    logic                  in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= bdlp_pkg::LOCKOUT_RST;
            r_settle  <= bdlp_pkg::SETTLE_RST;
            r_long    <= bdlp_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdlp_pkg::CFG_LOCKOUT: r_lockout <= i_cfg_data;
                bdlp_pkg::CFG_SETTLE:  r_settle  <= i_cfg_data;
                bdlp_pkg::CFG_LONG:    r_long    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp register values into the counter range
    generate
        if (COUNT_BITS >= CW) begin : g_wide
            assign lockout_lim = COUNT_BITS'(r_lockout);
            assign settle_lim  = COUNT_BITS'(r_settle);
            assign long_lim    = COUNT_BITS'(r_long);
        end else begin : g_narrow
            assign lockout_lim = (|r_lockout[CW-1:COUNT_BITS]) ? '1
                                                               : r_lockout[COUNT_BITS-1:0];
            assign settle_lim  = (|r_settle[CW-1:COUNT_BITS]) ? '1
                                                              : r_settle[COUNT_BITS-1:0];
            assign long_lim    = (|r_long[CW-1:COUNT_BITS]) ? '1
                                                            : r_long[COUNT_BITS-1:0];
        end
    endgenerate

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign levels = {i_in_data.select_level, i_in_data.right_level,
                     i_in_data.left_level, i_in_data.down_level, i_in_data.up_level};

    genvar g;
    generate
        for (g = 0; g < bdlp_pkg::DIR_N; g++) begin : g_dir
            bdlp_lane #(
                .COUNT_BITS(COUNT_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (in_acc),
                .i_prev   (r_prev[g]),
                .i_now    (levels[g]),
                .i_reload (lockout_lim),
                .o_event  (dir_ev[g])
            );
        end
    endgenerate

    bdlp_select #(
        .COUNT_BITS(COUNT_BITS)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (in_acc),
        .i_prev      (r_prev[4]),
        .i_now       (levels[4]),
        .i_settle_ld (settle_lim),
        .i_long_ld   (long_lim),
        .o_ev        (sel_ev)
    );

    always_comb begin
        n_out_data.up_event           = dir_ev[0];
        n_out_data.down_event         = dir_ev[1];
        n_out_data.left_event         = dir_ev[2];
        n_out_data.right_event        = dir_ev[3];
        n_out_data.select_short_event = sel_ev.short_ev;
        n_out_data.select_long_event  = sel_ev.long_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_prev      <= levels;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: load on every accepted tick, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/bdlp_lane.sv
// One direction button: falling-edge press report with lockout count.
module bdlp_lane #(
    parameter int COUNT_BITS = bdlp_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_prev,
    input  logic                  i_now,
    input  logic [COUNT_BITS-1:0] i_reload,
    output logic                  o_event
);

    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;

    always_comb begin
        dec_cnt = (r_cnt != '0) ? r_cnt - COUNT_BITS'(1) : r_cnt;
        o_event = i_prev && !i_now && (dec_cnt == '0);
        n_cnt   = o_event ? i_reload : dec_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/bdlp_select.sv
// Select button: settle debounce, confirmed state and long-press timing.
module bdlp_select #(
    parameter int COUNT_BITS = bdlp_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_prev,
    input  logic                  i_now,
    input  logic [COUNT_BITS-1:0] i_settle_ld,
    input  logic [COUNT_BITS-1:0] i_long_ld,
    output bdlp_pkg::t_sel_ev     o_ev
);

    logic [COUNT_BITS-1:0] r_settle_cnt, n_settle_cnt;
    logic                  r_settle_armed, n_settle_armed;
    logic                  r_confirmed, n_confirmed;
    logic [COUNT_BITS-1:0] r_long_cnt, n_long_cnt;
    logic                  r_long_armed, n_long_armed;
    logic                  r_long_rep, n_long_rep;
    logic                  long_loaded;
    logic                  pressed;

    always_comb begin
        n_settle_cnt   = r_settle_cnt;
        n_settle_armed = r_settle_armed;
        n_confirmed    = r_confirmed;
        n_long_cnt     = r_long_cnt;
        n_long_armed   = r_long_armed;
        n_long_rep     = r_long_rep;
        long_loaded    = 1'b0;
        pressed        = !i_now;
        o_ev           = '0;

        if (i_now != i_prev) begin
            // restart settle on any edge
            n_settle_cnt   = i_settle_ld;
            n_settle_armed = 1'b1;
        end else if (r_settle_armed) begin
            if (r_settle_cnt != '0) begin
                n_settle_cnt = r_settle_cnt - COUNT_BITS'(1);
            end
            if (n_settle_cnt == '0) begin
                n_settle_armed = 1'b0;
                if (pressed != r_confirmed) begin
                    n_confirmed = pressed;
                    if (pressed) begin
                        n_long_rep   = 1'b0;
                        n_long_cnt   = i_long_ld;
                        n_long_armed = 1'b1;
                        long_loaded  = 1'b1;
                    end else begin
                        n_long_armed = 1'b0;
                        n_long_cnt   = '0;
                        o_ev.short_ev = !r_long_rep;
                    end
                end
            end
        end

        // long count sees the settle outcome of this tick
        if (n_long_armed && !long_loaded) begin
            if (n_long_cnt != '0) begin
                n_long_cnt = n_long_cnt - COUNT_BITS'(1);
            end
            if (n_long_cnt == '0) begin
                n_long_armed = 1'b0;
                if (n_confirmed && !i_now) begin
                    n_long_rep   = 1'b1;
                    o_ev.long_ev = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_cnt   <= '0;
            r_settle_armed <= 1'b0;
            r_confirmed    <= 1'b0;
            r_long_cnt     <= '0;
            r_long_armed   <= 1'b0;
            r_long_rep     <= 1'b0;
        end else if (i_adv) begin
            r_settle_cnt   <= n_settle_cnt;
            r_settle_armed <= n_settle_armed;
            r_confirmed    <= n_confirmed;
            r_long_cnt     <= n_long_cnt;
            r_long_armed   <= n_long_armed;
            r_long_rep     <= n_long_rep;
        end
    end

endmodule

FILE: rtl/bdlp_checker.sv
// Port-level checks for the button front end, bound to the top level.
module bdlp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bdlp_pkg::t_out o_out_data
);

    // input side stalls only behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a held result beat");

    // every accepted tick yields a result beat next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted tick produced no result beat");

    // a held result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // release and long report cannot share a tick
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.select_short_event && o_out_data.select_long_event))
        else $error("short and long select events in one beat");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: test/bdlp_event_checker.sv
// Checker for the button debounce block: predicts the events of each tick and compares them.
`timescale 1ns / 1ps

module bdlp_event_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  bdlp_pkg::t_in                  i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  bdlp_pkg::t_out                 i_out_data,
    input  logic                           i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    string event_name [6] = '{"up", "down", "left", "right", "select_short", "select_long"};

    // programmed tick counts
    logic [bdlp_pkg::CFG_W-1:0] lock_ticks;
    logic [bdlp_pkg::CFG_W-1:0] settle_ticks;
    logic [bdlp_pkg::CFG_W-1:0] long_ticks;

    // button state, directions indexed up, down, left, right; bit 4 is select
    logic [4:0]                 prev_lv;
    logic [bdlp_pkg::CFG_W-1:0] lock_cnt [bdlp_pkg::DIR_N];
    logic [bdlp_pkg::CFG_W-1:0] settle_cnt;
    logic                       settle_on;
    logic                       sel_down;
    logic [bdlp_pkg::CFG_W-1:0] long_cnt;
    logic                       long_on;
    logic                       long_sent;

    bdlp_pkg::t_out expected_events [$];
    int             bad_count;
    int             shown;

    function automatic bdlp_pkg::t_out next_events(bdlp_pkg::t_in beat);
        logic [4:0]                 lv;
        logic [bdlp_pkg::DIR_N-1:0] dir_ev;
        logic                       sel_now;
        logic                       long_fresh;
        logic                       short_ev;
        logic                       long_ev;
        logic                       pressed;
        bdlp_pkg::t_out             res;
        lv = {beat.select_level, beat.right_level, beat.left_level,
              beat.down_level, beat.up_level};
        dir_ev     = '0;
        long_fresh = 1'b0;
        short_ev   = 1'b0;
        long_ev    = 1'b0;
        for (int i = 0; i < bdlp_pkg::DIR_N; i++) begin
            if (lock_cnt[i] != 0)
                lock_cnt[i] = lock_cnt[i] - 1'b1;
            if (prev_lv[i] && !lv[i] && lock_cnt[i] == 0) begin
                dir_ev[i]   = 1'b1;
                lock_cnt[i] = lock_ticks;
            end
        end
        sel_now = lv[4];
        if (sel_now != prev_lv[4]) begin
            // any select edge restarts the settle count
            settle_cnt = settle_ticks;
            settle_on  = 1'b1;
        end else if (settle_on) begin
            if (settle_cnt != 0)
                settle_cnt = settle_cnt - 1'b1;
            if (settle_cnt == 0) begin
                pressed   = !sel_now;
                settle_on = 1'b0;
                if (pressed != sel_down) begin
                    sel_down = pressed;
                    if (pressed) begin
                        long_sent  = 1'b0;
                        long_cnt   = long_ticks;
                        long_on    = 1'b1;
                        long_fresh = 1'b1;
                    end else begin
                        long_on  = 1'b0;
                        long_cnt = '0;
                        if (!long_sent)
                            short_ev = 1'b1;
                    end
                end
            end
        end
        // long count holds on the tick it is loaded
        if (long_on && !long_fresh) begin
            if (long_cnt != 0)
                long_cnt = long_cnt - 1'b1;
            if (long_cnt == 0) begin
                long_on = 1'b0;
                if (sel_down && !sel_now) begin
                    long_sent = 1'b1;
                    long_ev   = 1'b1;
                end
            end
        end
        prev_lv = lv;
        res.up_event           = dir_ev[0];
        res.down_event         = dir_ev[1];
        res.left_event         = dir_ev[2];
        res.right_event        = dir_ev[3];
        res.select_short_event = short_ev;
        res.select_long_event  = long_ev;
        return res;
    endfunction

    always @(posedge i_clk) begin
        bdlp_pkg::t_out want;
        bit             miss;
        if (!i_rst_n) begin
            lock_ticks   = bdlp_pkg::LOCKOUT_RST;
            settle_ticks = bdlp_pkg::SETTLE_RST;
            long_ticks   = bdlp_pkg::LONG_RST;
            prev_lv      = '1;
            foreach (lock_cnt[i])
                lock_cnt[i] = '0;
            settle_cnt = '0;
            settle_on  = 1'b0;
            sel_down   = 1'b0;
            long_cnt   = '0;
            long_on    = 1'b0;
            long_sent  = 1'b0;
            expected_events.delete();
            bad_count = 0;
            shown     = 0;
        end else begin
            // compare first: a beat leaving now belongs to an earlier tick
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    if (shown < 10)
                        $display("unexpected result beat %06b at %0t", i_out_data, $realtime);
                    shown++;
                    bad_count++;
                end else begin
                    want = expected_events.pop_front();
                    miss = 1'b0;
                    for (int f = 0; f < 6; f++) begin
                        if (want[5-f] !== i_out_data[5-f]) begin
                            if (shown < 10)
                                $display("%s event mismatch at %0t: expected %b, got %b",
                                         event_name[f], $realtime, want[5-f],
                                         i_out_data[5-f]);
                            shown++;
                            miss = 1'b1;
                        end
                    end
                    if (miss)
                        bad_count++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_events.push_back(next_events(i_in_data));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bdlp_pkg::CFG_LOCKOUT: lock_ticks   = i_cfg_data;
                    bdlp_pkg::CFG_SETTLE:  settle_ticks = i_cfg_data;
                    bdlp_pkg::CFG_LONG:    long_ticks   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= bad_count;
    end

endmodule

FILE: test/button_debounce_long_press_core_test.sv
// Testbench top for the button debounce core: clock, reset, button stimulus and verdict.
`timescale 1ns / 1ps

module button_debounce_long_press_core_test;

    localparam logic [bdlp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int LIMIT_NS       = 4_000_000;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    bdlp_pkg::t_in                  in_data   = '1;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index = bdlp_pkg::CFG_LOCKOUT;
    logic [bdlp_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           in_stall;
    logic                           out_valid;
    bdlp_pkg::t_out                 out_data;
    int                             pending;
    int                             fail_count;

    bit         idle_on     = 1'b0;
    int         squeeze_req = 0;
    logic [4:0] levels_now  = '1;

    // opening ticks, bits up, down, left, right, select; 0 is pressed
    logic [4:0] opening_ticks [24] = '{
        5'b11111, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000,
        5'b11111, 5'b11111, 5'b01110, 5'b01110, 5'b01111, 5'b01110,
        5'b01110, 5'b11111, 5'b11111, 5'b11110, 5'b11110, 5'b11111,
        5'b11111, 5'b10101, 5'b11111, 5'b10101, 5'b11111, 5'b10101
    };

    button_debounce_long_press_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bdlp_event_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("[button_debounce_long_press_core] ERROR");
        $finish;
    end

    // result side: random stall, plus a long hold-off on each request
    initial begin : result_side
        int squeeze_seen;
        squeeze_seen = 0;
        forever begin
            @(posedge clk);
            if (squeeze_req != squeeze_seen) begin
                squeeze_seen = squeeze_req;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            out_stall <= idle_on && ($urandom_range(0, 99) < 31);
        end
    end

    task automatic send_tick(input bdlp_pkg::t_in beat);
        while (idle_on && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and hold until every beat has come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlp_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // direction buttons chatter at random; select is held in runs sized
    // around the settle and long-press counts, with bounces and noise
    task automatic play_buttons(input int n, input int settle, input int hold);
        int run_left;
        int s_cap;
        int l_cap;
        s_cap    = (settle > 40) ? 40 : settle;
        l_cap    = (hold > 80) ? 80 : hold;
        run_left = 0;
        for (int k = 0; k < n; k++) begin
            for (int b = 1; b < 5; b++)
                if ($urandom_range(0, 5) == 0)
                    levels_now[b] = ~levels_now[b];
            if ($urandom_range(0, 24) == 0) begin
                levels_now = 5'($urandom);
                run_left   = 0;
            end else if (run_left == 0) begin
                levels_now[0] = ~levels_now[0];
                case ($urandom_range(0, 9))
                    0, 1:    run_left = $urandom_range(1, 2);
                    2, 3:    run_left = $urandom_range(1, s_cap + 1);
                    4, 5, 6: run_left = s_cap + 1 + $urandom_range(0, l_cap);
                    default: run_left = s_cap + l_cap + $urandom_range(1, 12);
                endcase
            end
            send_tick(bdlp_pkg::t_in'(levels_now));
            if (run_left > 0)
                run_left--;
        end
    endtask

    task automatic run_phase(input logic [bdlp_pkg::CFG_W-1:0] lock,
                             input logic [bdlp_pkg::CFG_W-1:0] settle,
                             input logic [bdlp_pkg::CFG_W-1:0] hold,
                             input int n, input bit idle);
        wait_quiet();
        write_reg(bdlp_pkg::CFG_LOCKOUT, lock);
        write_reg(bdlp_pkg::CFG_SETTLE, settle);
        write_reg(bdlp_pkg::CFG_LONG, hold);
        idle_on     <= idle;
        squeeze_req <= squeeze_req + 1;
        play_buttons(n, int'(settle), int'(hold));
    endtask

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset counts first
        idle_on     <= 1'b1;
        squeeze_req <= squeeze_req + 1;
        play_buttons(150, int'(bdlp_pkg::SETTLE_RST), int'(bdlp_pkg::LONG_RST));

        // a write to the spare index must change nothing
        wait_quiet();
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(bdlp_pkg::CFG_LOCKOUT, 16'd2);
        write_reg(bdlp_pkg::CFG_SETTLE, 16'd1);
        write_reg(bdlp_pkg::CFG_LONG, 16'd3);
        idle_on <= 1'b0;
        foreach (opening_ticks[k])
            send_tick(bdlp_pkg::t_in'(opening_ticks[k]));

        run_phase(16'd0, 16'd0, 16'd0, 150, 1'b1);
        run_phase(16'd1, 16'd1, 16'd1, 150, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b1);
        run_phase(16'hFFFF, 16'd2, 16'd8, 150, 1'b1);
        for (int p = 0; p < 6; p++)
            run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(1, 10)),
                      16'($urandom_range(1, 40)), 140, $urandom_range(0, 3) != 0);
        wait_quiet();

        if (fail_count == 0 && pending == 0)
            $display("[button_debounce_long_press_core] OK");
        else
            $display("[button_debounce_long_press_core] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bdlp_pkg.sv
rtl/bdlp_lane.sv
rtl/bdlp_select.sv
rtl/button_debounce_long_press_core.sv
rtl/bdlp_checker.sv
test/bdlp_event_checker.sv
test/button_debounce_long_press_core_test.sv
